@@ hw/rtl/tct_pkg.sv @@
package tct_pkg;

  typedef enum logic [2:0] {
    ST_SYN_SENT     = 3'd0,
    ST_SYN_RECEIVED = 3'd1,
    ST_ESTABLISHED  = 3'd2,
    ST_FIN_SEEN     = 3'd3,
    ST_CLOSED       = 3'd4
  } tcp_state_t;

  typedef struct packed {
    logic        is_ipv6;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_fin;
    logic        flag_rst;
    logic [15:0] packet_length;
  } pkt_t;

  typedef struct packed {
    logic [6:0]  entry_index;
    logic        was_found;
    logic        was_created;
    logic        table_full;
    logic [2:0]  prior_state;
    logic [2:0]  new_state;
    logic [63:0] byte_total;
    logic [7:0]  flow_count;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_READ,
    BK_UPDATE,
    BK_OUT
  } bk_state_t;

  function automatic logic [2:0] next_tcp_state(logic [2:0] s, logic syn, logic ack,
                                                logic fin, logic rst);
    logic [2:0] n;
    n = s;
    case (s)
      ST_SYN_SENT:     if (syn && ack) n = ST_SYN_RECEIVED;
      ST_SYN_RECEIVED: if (ack && !syn) n = ST_ESTABLISHED;
      ST_ESTABLISHED: begin
        if (fin) n = ST_FIN_SEEN;
        else if (rst) n = ST_CLOSED;
      end
      ST_FIN_SEEN:     if (ack) n = ST_CLOSED;
      default:         n = s;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/tct_if.sv @@
interface tct_pkt_if;
  import tct_pkg::*;
  logic valid;
  logic ready;
  pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tct_res_if;
  import tct_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/tct_front.sv @@
// Two-entry packet queue with registered output.
module tct_front import tct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tct_pkt_if.sink   in_pkt,
  tct_pkt_if.source q_pkt
);
  pkt_t       buf_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_pkt.ready = (cnt_r != 2'd2);
  assign push = in_pkt.valid && in_pkt.ready;
  assign q_pkt.valid = (cnt_r != 2'd0);
  assign q_pkt.data = buf_r[rp_r];
  assign pop = q_pkt.valid && q_pkt.ready;

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) buf_r[wp_r] <= in_pkt.data;
  end
endmodule

@@ hw/rtl/tct_back.sv @@
// Flow table: key memory scanned one entry a cycle, then read-modify-write of state and bytes.
module tct_back import tct_pkg::*; #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic clk,
  input  logic rst_n,
  tct_pkt_if.sink   q_pkt,
  tct_res_if.source out_res
);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int KW = 1 + 4 * 64 + 32;

  logic [KW-1:0] key_mem [MAX_ENTRIES];
  logic [2:0]    st_mem  [MAX_ENTRIES];
  logic [63:0]   by_mem  [MAX_ENTRIES];

  bk_state_t     st_r, st_nxt;
  pkt_t          pkt_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, hit_idx_r, hit_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [KW-1:0] key_q_r;
  logic [2:0]    st_q_r;
  logic [63:0]   by_q_r;
  res_t          res_r, res_nxt;
  logic          key_we, rw_we;
  logic [2:0]    wr_st;
  logic [63:0]   wr_by;
  logic          kmatch;
  logic [IW-1:0] wr_idx;

  // stored key layout: family, src_hi, src_lo, dst_hi, dst_lo, sport, dport
  logic          k_fam;
  logic [63:0]   k_sh, k_sl, k_dh, k_dl;
  logic [31:0]   k_pp;
  logic          eq_s_s, eq_d_d, eq_s_d, eq_d_s;

  assign {k_fam, k_sh, k_sl, k_dh, k_dl, k_pp} = key_q_r;

  always_comb begin
    if (pkt_r.is_ipv6) begin
      eq_s_s = (k_sh == pkt_r.src_addr_hi) && (k_sl == pkt_r.src_addr_lo);
      eq_d_d = (k_dh == pkt_r.dst_addr_hi) && (k_dl == pkt_r.dst_addr_lo);
      eq_s_d = (k_sh == pkt_r.dst_addr_hi) && (k_sl == pkt_r.dst_addr_lo);
      eq_d_s = (k_dh == pkt_r.src_addr_hi) && (k_dl == pkt_r.src_addr_lo);
    end else begin
      eq_s_s = k_sl[31:0] == pkt_r.src_addr_lo[31:0];
      eq_d_d = k_dl[31:0] == pkt_r.dst_addr_lo[31:0];
      eq_s_d = k_sl[31:0] == pkt_r.dst_addr_lo[31:0];
      eq_d_s = k_dl[31:0] == pkt_r.src_addr_lo[31:0];
    end
    kmatch = (k_fam == pkt_r.is_ipv6) &&
             ((k_pp == {pkt_r.sport, pkt_r.dport} && eq_s_s && eq_d_d) ||
              (k_pp == {pkt_r.dport, pkt_r.sport} && eq_s_d && eq_d_s));
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:   if (q_pkt.valid) st_nxt = BK_SEARCH;
      BK_SEARCH: if ((rd_vld_r && kmatch) || (!rd_vld_r && scan_r == used_r))
                   st_nxt = BK_READ;
      BK_READ:   st_nxt = BK_UPDATE;
      BK_UPDATE: st_nxt = BK_OUT;
      BK_OUT:    if (out_res.ready) st_nxt = BK_IDLE;
      default:   st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    scan_nxt = scan_r;
    rd_vld_nxt = 1'b0;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    used_nxt = used_r;
    res_nxt = res_r;
    key_we = 1'b0;
    rw_we = 1'b0;
    wr_st = st_q_r;
    wr_by = by_q_r;
    wr_idx = hit_idx_r;
    case (st_r)
      BK_IDLE: begin
        scan_nxt = '0;
        hit_nxt = 1'b0;
      end
      BK_SEARCH: begin
        if (rd_vld_r && kmatch) begin
          hit_nxt = 1'b1;
          hit_idx_nxt = rd_idx_r;
        end else if (scan_r != used_r) begin
          rd_vld_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end
      end
      BK_UPDATE: begin
        res_nxt = '0;
        if (hit_r) begin
          wr_st = next_tcp_state(st_q_r, pkt_r.flag_syn, pkt_r.flag_ack,
                                 pkt_r.flag_fin, pkt_r.flag_rst);
          wr_by = by_q_r + {48'd0, pkt_r.packet_length};
          rw_we = 1'b1;
          res_nxt.entry_index = 7'(hit_idx_r);
          res_nxt.was_found = 1'b1;
          res_nxt.prior_state = st_q_r;
        end else if (used_r != CW'(MAX_ENTRIES)) begin
          wr_idx = used_r[IW-1:0];
          if (pkt_r.flag_syn && !pkt_r.flag_ack) wr_st = ST_SYN_SENT;
          else if (pkt_r.flag_syn) wr_st = ST_SYN_RECEIVED;
          else wr_st = ST_ESTABLISHED;
          wr_by = {48'd0, pkt_r.packet_length};
          rw_we = 1'b1;
          key_we = 1'b1;
          used_nxt = used_r + 1'b1;
          res_nxt.entry_index = 7'(used_r);
          res_nxt.was_created = 1'b1;
          res_nxt.prior_state = wr_st;
        end else begin
          res_nxt.table_full = 1'b1;
        end
        if (rw_we) begin
          res_nxt.new_state = wr_st;
          res_nxt.byte_total = wr_by;
        end
        res_nxt.flow_count = 8'(used_nxt);
      end
      default: ;
    endcase
  end

  assign q_pkt.ready = (st_r == BK_IDLE);
  assign out_res.valid = (st_r == BK_OUT);
  assign out_res.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      used_r <= '0;
      rd_vld_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      used_r <= used_nxt;
      rd_vld_r <= rd_vld_nxt;
      hit_r <= hit_nxt;
    end
    scan_r <= scan_nxt;
    hit_idx_r <= hit_idx_nxt;
    res_r <= res_nxt;
    if (q_pkt.valid && q_pkt.ready) pkt_r <= q_pkt.data;
  end

  // key memory: one read port driven by the scan pointer
  always_ff @(posedge clk) begin
    key_q_r <= key_mem[scan_r[IW-1:0]];
    rd_idx_r <= scan_r[IW-1:0];
    if (key_we)
      key_mem[wr_idx] <= {pkt_r.is_ipv6, pkt_r.src_addr_hi, pkt_r.src_addr_lo,
                          pkt_r.dst_addr_hi, pkt_r.dst_addr_lo,
                          pkt_r.sport, pkt_r.dport};
  end

  always_ff @(posedge clk) begin
    st_q_r <= st_mem[hit_idx_r];
    by_q_r <= by_mem[hit_idx_r];
    if (rw_we) begin
      st_mem[wr_idx] <= wr_st;
      by_mem[wr_idx] <= wr_by;
    end
  end
endmodule

@@ hw/rtl/tcp_connection_tracker.sv @@
// TCP flow tracker. Each packet is queued, then the flow table is scanned one
// stored flow per cycle from index 0 until the first match in either direction
// or the end of the occupied entries, through the single read port of the key
// memory; a miss scans every stored flow, a hit at index i stops there. One
// packet is in the table at a time. A result stays on out_ until taken; the
// two-deep input queue keeps accepting meanwhile until it is full. No clearing
// pass: entries are only read below the fill count.
module tcp_connection_tracker import tct_pkg::*; #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic clk,
  input  logic rst_n,
  tct_pkt_if.sink   in_pkt,
  tct_res_if.source out_res
);
  tct_pkt_if q_pkt ();

  tct_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pkt (in_pkt),
    .q_pkt  (q_pkt)
  );

  tct_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_pkt   (q_pkt),
    .out_res (out_res)
  );
endmodule

@@ tb/flow_checker.sv @@
module flow_checker import tct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tct_pkt_if   pkt_mon,
  tct_res_if   res_mon,
  output int   fail_count,
  output int   pending
);

  localparam int TABLE_DEPTH = 128;

  logic        fam_tab   [TABLE_DEPTH];
  logic [63:0] src_hi_tab[TABLE_DEPTH];
  logic [63:0] src_lo_tab[TABLE_DEPTH];
  logic [63:0] dst_hi_tab[TABLE_DEPTH];
  logic [63:0] dst_lo_tab[TABLE_DEPTH];
  logic [31:0] ports_tab [TABLE_DEPTH];
  tcp_state_t  conn_tab  [TABLE_DEPTH];
  logic [63:0] bytes_tab [TABLE_DEPTH];
  int          flows_used;
  res_t        expected_q[$];

  function automatic bit addr_match(logic v6, logic [63:0] ahi, logic [63:0] alo,
                                    logic [63:0] bhi, logic [63:0] blo);
    if (v6) return (ahi == bhi) && (alo == blo);
    return alo[31:0] == blo[31:0];
  endfunction

  function automatic tcp_state_t step_conn(tcp_state_t s, logic syn, logic ack,
                                           logic fin, logic rst);
    case (s)
      ST_SYN_SENT:     return (syn && ack) ? ST_SYN_RECEIVED : s;
      ST_SYN_RECEIVED: return (ack && !syn) ? ST_ESTABLISHED : s;
      ST_ESTABLISHED: begin
        if (fin) return ST_FIN_SEEN;
        if (rst) return ST_CLOSED;
        return s;
      end
      ST_FIN_SEEN:     return ack ? ST_CLOSED : s;
      default:         return s;
    endcase
  endfunction

  task automatic track_packet(input pkt_t p, output res_t r);
    logic [31:0] fwd;
    logic [31:0] rev;
    int          hit;
    tcp_state_t  init_st;
    fwd = {p.sport, p.dport};
    rev = {p.dport, p.sport};
    hit = -1;
    r = '0;
    for (int i = 0; i < flows_used && hit < 0; i++) begin
      if (fam_tab[i] == p.is_ipv6) begin
        if (ports_tab[i] == fwd &&
            addr_match(p.is_ipv6, src_hi_tab[i], src_lo_tab[i], p.src_addr_hi, p.src_addr_lo) &&
            addr_match(p.is_ipv6, dst_hi_tab[i], dst_lo_tab[i], p.dst_addr_hi, p.dst_addr_lo))
          hit = i;
        else if (ports_tab[i] == rev &&
            addr_match(p.is_ipv6, src_hi_tab[i], src_lo_tab[i], p.dst_addr_hi, p.dst_addr_lo) &&
            addr_match(p.is_ipv6, dst_hi_tab[i], dst_lo_tab[i], p.src_addr_hi, p.src_addr_lo))
          hit = i;
      end
    end
    if (hit >= 0) begin
      r.entry_index = hit[6:0];
      r.was_found   = 1'b1;
      r.prior_state = conn_tab[hit];
      conn_tab[hit] = step_conn(conn_tab[hit], p.flag_syn, p.flag_ack, p.flag_fin, p.flag_rst);
      r.new_state   = conn_tab[hit];
      bytes_tab[hit] = bytes_tab[hit] + 64'(p.packet_length);
      r.byte_total  = bytes_tab[hit];
    end else if (flows_used < TABLE_DEPTH) begin
      if (p.flag_syn && !p.flag_ack) init_st = ST_SYN_SENT;
      else if (p.flag_syn)           init_st = ST_SYN_RECEIVED;
      else                           init_st = ST_ESTABLISHED;
      fam_tab[flows_used]    = p.is_ipv6;
      src_hi_tab[flows_used] = p.src_addr_hi;
      src_lo_tab[flows_used] = p.src_addr_lo;
      dst_hi_tab[flows_used] = p.dst_addr_hi;
      dst_lo_tab[flows_used] = p.dst_addr_lo;
      ports_tab[flows_used]  = fwd;
      conn_tab[flows_used]   = init_st;
      bytes_tab[flows_used]  = 64'(p.packet_length);
      r.entry_index = flows_used[6:0];
      r.was_created = 1'b1;
      r.prior_state = init_st;
      r.new_state   = init_st;
      r.byte_total  = 64'(p.packet_length);
      flows_used++;
    end else begin
      r.table_full = 1'b1;
    end
    r.flow_count = flows_used[7:0];
  endtask

  task automatic report(string field, logic [63:0] exp_v, logic [63:0] got_v);
    $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, field, exp_v, got_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    flows_used = 0;
  end

  always @(posedge clk) begin
    res_t exp_r;
    res_t got_r;
    if (rst_n) begin
      if (res_mon.valid && res_mon.ready) begin
        got_r = res_mon.data;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual %h",
                   $time, got_r);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r.entry_index !== exp_r.entry_index)
            report("entry_index", 64'(exp_r.entry_index), 64'(got_r.entry_index));
          if (got_r.was_found !== exp_r.was_found)
            report("was_found", 64'(exp_r.was_found), 64'(got_r.was_found));
          if (got_r.was_created !== exp_r.was_created)
            report("was_created", 64'(exp_r.was_created), 64'(got_r.was_created));
          if (got_r.table_full !== exp_r.table_full)
            report("table_full", 64'(exp_r.table_full), 64'(got_r.table_full));
          if (got_r.prior_state !== exp_r.prior_state)
            report("prior_state", 64'(exp_r.prior_state), 64'(got_r.prior_state));
          if (got_r.new_state !== exp_r.new_state)
            report("new_state", 64'(exp_r.new_state), 64'(got_r.new_state));
          if (got_r.byte_total !== exp_r.byte_total)
            report("byte_total", exp_r.byte_total, got_r.byte_total);
          if (got_r.flow_count !== exp_r.flow_count)
            report("flow_count", 64'(exp_r.flow_count), 64'(got_r.flow_count));
        end
      end
      if (pkt_mon.valid && pkt_mon.ready) begin
        track_packet(pkt_mon.data, exp_r);
        expected_q.push_back(exp_r);
      end
      pending <= expected_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  import tct_pkg::*;

  localparam int  RANDOM_ITEMS = 1930;
  localparam int  KEY_POOL     = 160;
  localparam int  CYCLE_LIMIT  = 3000000;
  localparam int  HOLD_CYCLES  = 900;
  localparam int  HOLD_AT      = 400;
  localparam int  DRAIN_AT     = 1400;
  localparam int  CALM_FROM    = 900;
  localparam int  CALM_TO      = 1150;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   sent;
  bit   hold_req;
  int   hold_left;

  tct_pkt_if pkt_ch ();
  tct_res_if res_ch ();

  tcp_connection_tracker u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pkt  (pkt_ch),
    .out_res (res_ch)
  );

  flow_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pkt_mon    (pkt_ch),
    .res_mon    (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  logic        key_v6   [KEY_POOL];
  logic [63:0] key_a_hi [KEY_POOL];
  logic [63:0] key_a_lo [KEY_POOL];
  logic [63:0] key_b_hi [KEY_POOL];
  logic [63:0] key_b_lo [KEY_POOL];
  logic [15:0] key_a_pt [KEY_POOL];
  logic [15:0] key_b_pt [KEY_POOL];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit calm();
    return sent >= CALM_FROM && sent < CALM_TO;
  endfunction

  // hold off the result side once for a long stretch so the input queue backs up
  always @(negedge clk) begin
    if (hold_req && hold_left == 0 && sent < HOLD_AT + 5) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm() ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  task automatic send(input pkt_t p);
    while (!calm() && $urandom_range(99) < 26) begin
      @(negedge clk);
      pkt_ch.valid <= 1'b0;
    end
    @(negedge clk);
    pkt_ch.valid <= 1'b1;
    pkt_ch.data  <= p;
    @(posedge clk);
    while (!pkt_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic pkt_t mk_pkt(logic v6, logic [63:0] shi, logic [63:0] slo,
                                  logic [63:0] dhi, logic [63:0] dlo,
                                  logic [15:0] sp, logic [15:0] dp, logic [3:0] flags,
                                  logic [15:0] len);
    pkt_t p;
    p.is_ipv6 = v6;
    p.src_addr_hi = shi;
    p.src_addr_lo = slo;
    p.dst_addr_hi = dhi;
    p.dst_addr_lo = dlo;
    p.sport = sp;
    p.dport = dp;
    {p.flag_syn, p.flag_ack, p.flag_fin, p.flag_rst} = flags;
    p.packet_length = len;
    return p;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // flag nibble order: syn, ack, fin, rst
  localparam logic [3:0] F_SYN    = 4'b1000;
  localparam logic [3:0] F_SYNACK = 4'b1100;
  localparam logic [3:0] F_ACK    = 4'b0100;
  localparam logic [3:0] F_FINACK = 4'b0110;
  localparam logic [3:0] F_RST    = 4'b0001;
  localparam logic [3:0] F_FINRST = 4'b0011;
  localparam logic [3:0] F_NONE   = 4'b0000;
  localparam logic [3:0] F_ALL    = 4'b1111;

  task automatic directed_part();
    logic [63:0] ones;
    ones = '1;
    // IPv4 handshake, teardown and closed flow ignoring further flags
    send(mk_pkt(0, 0, 64'h0a000001, 0, 64'h0a000002, 16'd1000, 16'd80, F_SYN, 16'd60));
    send(mk_pkt(0, 0, 64'h0a000002, 0, 64'h0a000001, 16'd80, 16'd1000, F_SYNACK, 16'd60));
    send(mk_pkt(0, 0, 64'h0a000001, 0, 64'h0a000002, 16'd1000, 16'd80, F_ACK, 16'd0));
    send(mk_pkt(0, 0, 64'h0a000001, 0, 64'h0a000002, 16'd1000, 16'd80, F_FINACK, 16'hffff));
    send(mk_pkt(0, 0, 64'h0a000002, 0, 64'h0a000001, 16'd80, 16'd1000, F_ACK, 16'd1));
    send(mk_pkt(0, 0, 64'h0a000001, 0, 64'h0a000002, 16'd1000, 16'd80, F_ALL, 16'd5));
    // IPv4 compare ignores high halves and upper 32 bits of the low half
    send(mk_pkt(0, ones, 64'hdead_beef_0a000001, ones, 64'h1234_5678_0a000002,
                16'd1000, 16'd80, F_NONE, 16'd7));
    // same key as IPv6 is a different flow
    send(mk_pkt(1, 0, 64'h0a000001, 0, 64'h0a000002, 16'd1000, 16'd80, F_NONE, 16'd9));
    // established flow seeing FIN and RST together waits on the FIN
    send(mk_pkt(1, 0, 64'h0a000001, 0, 64'h0a000002, 16'd1000, 16'd80, F_FINRST, 16'd2));
    send(mk_pkt(1, 0, 64'h0a000002, 0, 64'h0a000001, 16'd80, 16'd1000, F_SYN, 16'd2));
    send(mk_pkt(1, 0, 64'h0a000002, 0, 64'h0a000001, 16'd80, 16'd1000, F_ACK, 16'd2));
    // IPv6 upper half differs: new flow
    send(mk_pkt(1, 64'h1, 64'h0a000001, 0, 64'h0a000002, 16'd1000, 16'd80, F_RST, 16'd3));
    // established then RST closes
    send(mk_pkt(0, 0, 64'hc0a80001, 0, 64'hc0a80002, 16'd5, 16'd6, F_ACK, 16'd0));
    send(mk_pkt(0, 0, 64'hc0a80002, 0, 64'hc0a80001, 16'd6, 16'd5, F_RST, 16'd0));
    // extremes of all fields
    send(mk_pkt(1, ones, ones, ones, ones, 16'hffff, 16'hffff, F_ALL, 16'hffff));
    send(mk_pkt(1, ones, ones, ones, ones, 16'hffff, 16'hffff, F_ALL, 16'hffff));
    send(mk_pkt(0, 0, 0, 0, 0, 16'd0, 16'd0, F_NONE, 16'd0));
    send(mk_pkt(0, 0, 0, 0, 0, 16'd0, 16'd0, F_SYNACK, 16'd0));
    send(mk_pkt(0, 0, 0, 0, 0, 16'd0, 16'd0, F_SYN, 16'd0));
    send(mk_pkt(0, 0, 0, 0, 0, 16'd0, 16'd0, F_ACK, 16'd0));
  endtask

  function automatic logic [3:0] pick_flags();
    case ($urandom_range(9))
      0: return F_SYN;
      1: return F_SYNACK;
      2, 3: return F_ACK;
      4: return F_FINACK;
      5: return F_RST;
      6: return F_FINRST;
      default: return 4'($urandom());
    endcase
  endfunction

  task automatic random_packet();
    int          k;
    pkt_t        p;
    logic [63:0] ahi, alo, bhi, blo;
    if ($urandom_range(99) < 12) begin
      p = mk_pkt(1'($urandom()), rand64(), rand64(), rand64(), rand64(),
                 16'($urandom()), 16'($urandom()), 4'($urandom()), 16'($urandom()));
    end else begin
      // after 600 sends keys come from indices 0 to 140 only, to favour hits once the table has filled
      k = (sent < 600) ? $urandom_range(KEY_POOL - 1) : $urandom_range(140);
      ahi = key_a_hi[k];
      alo = key_a_lo[k];
      bhi = key_b_hi[k];
      blo = key_b_lo[k];
      if (!key_v6[k]) begin
        ahi = rand64();
        bhi = rand64();
        alo[63:32] = $urandom();
        blo[63:32] = $urandom();
      end
      if ($urandom_range(1))
        p = mk_pkt(key_v6[k], ahi, alo, bhi, blo, key_a_pt[k], key_b_pt[k],
                   pick_flags(), 16'($urandom()));
      else
        p = mk_pkt(key_v6[k], bhi, blo, ahi, alo, key_b_pt[k], key_a_pt[k],
                   pick_flags(), 16'($urandom()));
    end
    send(p);
  endtask

  initial begin
    rst_n        = 1'b0;
    pkt_ch.valid = 1'b0;
    pkt_ch.data  = '0;
    res_ch.ready = 1'b0;
    cycles       = 0;
    sent         = 0;
    hold_req     = 1'b0;
    hold_left    = 0;
    for (int k = 0; k < KEY_POOL; k++) begin
      key_v6[k]   = 1'($urandom());
      key_a_hi[k] = rand64();
      key_a_lo[k] = rand64();
      key_b_hi[k] = ($urandom_range(3) == 0) ? key_a_hi[k] : rand64();
      key_b_lo[k] = ($urandom_range(7) == 0) ? key_a_lo[k] : rand64();
      key_a_pt[k] = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom());
      key_b_pt[k] = ($urandom_range(3) == 0) ? key_a_pt[k] : 16'($urandom());
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    directed_part();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (sent == HOLD_AT) hold_req = 1'b1;
      if (sent == DRAIN_AT) begin
        @(negedge clk);
        pkt_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      random_packet();
    end
    @(negedge clk);
    pkt_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tct_pkg.sv
hw/rtl/tct_if.sv
hw/rtl/tct_front.sv
hw/rtl/tct_back.sv
hw/rtl/tcp_connection_tracker.sv
tb/flow_checker.sv
tb/testbench.sv
